// ===== src/skf_pkg.sv =====
// Shared constants, types and command bundle for the scalar Kalman filter.
package skf_pkg;

  localparam int DATA_WIDTH_DEF    = 32;
  localparam int COV_FRAC_BITS_DEF = 28;

  localparam int COV_W   = 32;         // covariance and noise registers
  localparam int SUM_W   = COV_W + 1;  // P1 + R
  localparam int REM_W   = COV_W + 2;  // divider partial remainder
  localparam int MUL_A_W = 32;         // chunk width of the shared multiplier

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MEAS_NOISE    = 1'b1;

  localparam logic [COV_W-1:0] PN_RESET = 32'd2684;
  localparam logic [COV_W-1:0] MN_RESET = 32'd26844;

  typedef struct packed {
    logic load;
    logic setup;
    logic absv;
    logic div_step;
    logic mul_x;
    logic acc_x;
    logic mul_p;
    logic commit;
  } skf_cmd_t;

  typedef struct packed {
    logic out_free;
  } skf_sts_t;

endpackage

// ===== src/scalar_kalman_filter.sv =====
// Top level of the scalar Kalman filter: stream ports, controller and datapath.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+-------------------------------------------
//  in_       | in  | in_tvalid/tready   | tdata: measurement (signed Q16.16 default)
//  out_      | out | out_tvalid/tready  | tdata: estimate (signed Q16.16 default)
//  cfg_      | in  | cfg_wr_en          | cfg_addr: 0 process noise, 1 meas. noise
//
//  From acceptance until its result is presented and ready returns, one measurement
//  runs through setup, absolute value, the divider steps, a multiply and an
//  accumulate step per chunk, the covariance multiply and the commit, so a new
//  measurement is accepted only once the last one is through; the radix-2 gain
//  divider, one quotient bit a cycle, takes most of that time.
//  Reset (rst_n low, synchronous) restores both noise registers, clears the
//  estimate and sets the covariance to one.
//  The result sits in an output register; a new measurement is accepted while
//  it waits, and the update stalls only at its final commit until the slot frees.
module scalar_kalman_filter #(
  parameter int DATA_WIDTH    = skf_pkg::DATA_WIDTH_DEF,
  parameter int COV_FRAC_BITS = skf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Stream input
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0] in_tdata,   // [DATA_WIDTH-1:0] measurement
  // Stream output
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0] out_tdata,  // [DATA_WIDTH-1:0] estimate
  // Register writes
  input  logic                           cfg_wr_en,
  input  logic [skf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [skf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int CHUNKS  = (DATA_WIDTH + skf_pkg::MUL_A_W - 1) / skf_pkg::MUL_A_W;

  skf_pkg::skf_cmd_t            cmd;
  skf_pkg::skf_sts_t            sts;
  logic signed [DATA_WIDTH-1:0] est;

  // Sequencer: one command per state; the commit waits on datapath status.
  skf_ctrl #(
    .DIV_STEPS (COV_FRAC_BITS + 1),
    .CHUNKS    (CHUNKS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, filter state and the output holding register.
  skf_dp #(
    .DATA_WIDTH    (DATA_WIDTH),
    .COV_FRAC_BITS (COV_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .meas      ($signed(in_tdata[DATA_WIDTH-1:0])),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_est   (est)
  );

  // Pad the estimate with zeros up to a whole byte.
  assign out_tdata = TDATA_W'(unsigned'(est));

endmodule

// ===== src/skf_ctrl.sv =====
// Sequencing state machine for the scalar Kalman filter update.
module skf_ctrl #(
  parameter int DIV_STEPS = skf_pkg::COV_FRAC_BITS_DEF + 1,
  parameter int CHUNKS    = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  skf_pkg::skf_sts_t sts,
  output skf_pkg::skf_cmd_t cmd
);

  localparam int CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ABS,
    ST_DIV,
    ST_MULX,
    ST_ACCX,
    ST_MULP,
    ST_COMMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SETUP;
      end
      ST_SETUP: state_nxt = ST_ABS;
      ST_ABS: begin
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MULX;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MULX: state_nxt = ST_ACCX;
      ST_ACCX: begin
        if (cnt_r == CNT_W'(CHUNKS - 1)) begin
          state_nxt = ST_MULP;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_MULX;
        end
      end
      ST_MULP: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_tvalid;
    cmd.setup    = (state_r == ST_SETUP);
    cmd.absv     = (state_r == ST_ABS);
    cmd.div_step = (state_r == ST_DIV);
    cmd.mul_x    = (state_r == ST_MULX);
    cmd.acc_x    = (state_r == ST_ACCX);
    cmd.mul_p    = (state_r == ST_MULP);
    cmd.commit   = (state_r == ST_COMMIT) && sts.out_free;
  end

  a_div_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= CNT_W'(DIV_STEPS - 1)))
    else $error("divider step count out of range");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == ST_SETUP))
    else $error("accepted measurement did not start an update");

endmodule

// ===== src/skf_dp.sv =====
// Datapath: noise registers, filter state, radix-2 divider, shared multiplier.
module skf_dp #(
  parameter int DATA_WIDTH    = skf_pkg::DATA_WIDTH_DEF,
  parameter int COV_FRAC_BITS = skf_pkg::COV_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [skf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic signed [DATA_WIDTH-1:0]      meas,
  input  skf_pkg::skf_cmd_t                 cmd,
  output skf_pkg::skf_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [DATA_WIDTH-1:0]      out_est
);

  localparam int CW     = skf_pkg::MUL_A_W;
  localparam int GAIN_W = COV_FRAC_BITS + 1;
  localparam int NCH    = (DATA_WIDTH + CW - 1) / CW;
  localparam int MAGP_W = NCH * CW;
  localparam int PROD_W = CW + GAIN_W;
  localparam int ACC_W  = MAGP_W + GAIN_W;
  localparam int DIFF_W = DATA_WIDTH + 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << COV_FRAC_BITS;
  localparam logic [skf_pkg::COV_W-1:0] COV_ONE = skf_pkg::COV_W'(1) << COV_FRAC_BITS;

  logic [skf_pkg::COV_W-1:0]    pn_r, mn_r, p_r, p1_r;
  logic signed [DATA_WIDTH-1:0] x_r, m_r;
  logic [skf_pkg::SUM_W-1:0]    s_r;
  logic signed [DIFF_W-1:0]     diff_r;
  logic [MAGP_W-1:0]            mag_sh_r;
  logic                         neg_r, zden_r;
  logic [skf_pkg::REM_W-1:0]    rem_r;
  logic [GAIN_W-1:0]            q_r;
  logic [PROD_W-1:0]            prod_r;
  logic [ACC_W-1:0]             acc_r;
  logic                         out_valid_r;
  logic signed [DATA_WIDTH-1:0] out_est_r;

  logic [skf_pkg::SUM_W-1:0]    p_sum;
  logic [skf_pkg::COV_W-1:0]    p1_sat;
  logic [skf_pkg::REM_W:0]      trial;
  logic [skf_pkg::REM_W-1:0]    rem_keep;
  logic [GAIN_W-1:0]            gain;
  logic [CW-1:0]                mul_a;
  logic [GAIN_W-1:0]            mul_b;
  logic [DATA_WIDTH-1:0]        delta;
  logic signed [DATA_WIDTH-1:0] x_new;
  logic [DATA_WIDTH-1:0]        mag;

  // Covariance prediction with saturation.
  assign p_sum  = {1'b0, p_r} + {1'b0, pn_r};
  assign p1_sat = p_sum[skf_pkg::COV_W] ? '1 : p_sum[skf_pkg::COV_W-1:0];

  // Restoring divide step; remainder register holds the value to compare.
  assign trial    = {1'b0, rem_r} - {2'b00, s_r};
  assign rem_keep = trial[skf_pkg::REM_W] ? rem_r : trial[skf_pkg::REM_W-1:0];

  assign gain = zden_r ? GAIN_ONE : q_r;

  assign mag = neg_r ? DATA_WIDTH'(-diff_r) : DATA_WIDTH'(diff_r);

  // Shared multiplier operands: innovation chunks, then the covariance.
  always_comb begin
    if (cmd.mul_p) begin
      mul_a = CW'(p1_r);
      mul_b = GAIN_ONE - gain;
    end else begin
      mul_a = mag_sh_r[MAGP_W-1 -: CW];
      mul_b = gain;
    end
  end

  assign delta = acc_r[COV_FRAC_BITS +: DATA_WIDTH];
  assign x_new = neg_r ? (x_r - $signed(delta)) : (x_r + $signed(delta));

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r        <= skf_pkg::PN_RESET;
      mn_r        <= skf_pkg::MN_RESET;
      x_r         <= '0;
      p_r         <= COV_ONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_addr)
          skf_pkg::CFG_PROCESS_NOISE: pn_r <= cfg_wdata[skf_pkg::COV_W-1:0];
          skf_pkg::CFG_MEAS_NOISE:    mn_r <= cfg_wdata[skf_pkg::COV_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit) begin
        x_r         <= x_new;
        p_r         <= prod_r[COV_FRAC_BITS +: skf_pkg::COV_W];
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r  <= meas;
      p1_r <= p1_sat;
    end
    if (cmd.setup) begin
      s_r    <= {1'b0, p1_r} + {1'b0, mn_r};
      diff_r <= {m_r[DATA_WIDTH-1], m_r} - {x_r[DATA_WIDTH-1], x_r};
    end
    if (cmd.absv) begin
      neg_r    <= diff_r[DIFF_W-1];
      zden_r   <= (s_r == '0);
      rem_r    <= skf_pkg::REM_W'(p1_r);
      q_r      <= '0;
      acc_r    <= '0;
    end
    if (cmd.div_step) begin
      // First step also freezes the innovation magnitude.
      if (q_r == '0) mag_sh_r <= MAGP_W'(mag);
      q_r   <= {q_r[GAIN_W-2:0], !trial[skf_pkg::REM_W]};
      rem_r <= rem_keep << 1;
    end
    if (cmd.mul_x || cmd.mul_p) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.mul_x) begin
      mag_sh_r <= mag_sh_r << CW;
    end
    if (cmd.acc_x) begin
      acc_r <= (acc_r << CW) + ACC_W'(prod_r);
    end
    if (cmd.commit) begin
      out_est_r <= x_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_est   = out_est_r;

  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_p |-> (gain <= GAIN_ONE))
    else $error("gain exceeds one");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && (out_est_r == x_r)))
    else $error("committed estimate not presented");

  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (p_r <= $past(p1_r)))
    else $error("updated covariance above predicted covariance");

endmodule
